@@ design/sit_pkg.sv @@
package sit_pkg;

    localparam int CAPACITY_DEF      = 64;
    localparam int PAYLOAD_WIDTH_DEF = 16;

    localparam int DAY_W     = 5;
    localparam int HOURS_W   = 5;
    localparam int MINUTES_W = 6;
    localparam int KEY_W     = DAY_W + HOURS_W + MINUTES_W;
    localparam int PORT_PAY_W = 16;

    typedef logic [KEY_W-1:0] t_key;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_FULL   = 2'd1,
        KIND_ENTRY  = 2'd2,
        KIND_EMPTY  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ROTATE = 2'd2
    } t_cell_op;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op op;
        t_key     key;
    } t_cell_ctl;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DUMP   = 1'b1;

endpackage

@@ design/sit_in_if.sv @@
interface sit_in_if;
    import sit_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [DAY_W-1:0]      day;
    logic [HOURS_W-1:0]    hours;
    logic [MINUTES_W-1:0]  minutes;
    logic [PORT_PAY_W-1:0] payload;

    modport source (output valid, mode, day, hours, minutes, payload, input ready);
    modport sink   (input valid, mode, day, hours, minutes, payload, output ready);
endinterface

@@ design/sit_out_if.sv @@
interface sit_out_if;
    import sit_pkg::*;

    logic                  valid;
    logic                  ready;
    t_kind                 kind;
    logic [DAY_W-1:0]      out_day;
    logic [HOURS_W-1:0]    out_hours;
    logic [MINUTES_W-1:0]  out_minutes;
    logic [PORT_PAY_W-1:0] out_payload;
    logic                  last;

    modport source (output valid, kind, out_day, out_hours, out_minutes, out_payload, last,
                    input ready);
    modport sink   (input valid, kind, out_day, out_hours, out_minutes, out_payload, last,
                    output ready);
endinterface

@@ design/sit_cell.sv @@
module sit_cell #(
    parameter int CAPACITY      = sit_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_WIDTH = sit_pkg::PAYLOAD_WIDTH_DEF,
    parameter int CELL_IDX      = 0
) (
    input  logic                              i_clk,
    input  sit_pkg::t_cell_ctl                i_ctl,
    input  logic [PAYLOAD_WIDTH-1:0]          i_new_pay,
    input  logic [$clog2(CAPACITY+1)-1:0]     i_count,
    input  logic                              i_prev_lt,
    input  sit_pkg::t_key                     i_prev_key,
    input  logic [PAYLOAD_WIDTH-1:0]          i_prev_pay,
    input  sit_pkg::t_key                     i_next_key,
    input  logic [PAYLOAD_WIDTH-1:0]          i_next_pay,
    input  sit_pkg::t_key                     i_wrap_key,
    input  logic [PAYLOAD_WIDTH-1:0]          i_wrap_pay,
    output logic                              o_lt,
    output sit_pkg::t_key                     o_key,
    output logic [PAYLOAD_WIDTH-1:0]          o_pay
);
    import sit_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] IDX      = CNT_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(CELL_IDX + 1);

    t_key                     r_key;
    t_key                     n_key;
    logic [PAYLOAD_WIDTH-1:0] r_pay;
    logic [PAYLOAD_WIDTH-1:0] n_pay;
    logic                     w_tail;

    // The cell holds a live entry smaller than the new key.
    assign o_lt   = (IDX < i_count) && (r_key < i_ctl.key);
    assign w_tail = (i_count == IDX_NEXT);

    always_comb begin
        n_key = r_key;
        n_pay = r_pay;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (!o_lt) begin
                    if (i_prev_lt) begin
                        n_key = i_ctl.key;
                        n_pay = i_new_pay;
                    end else begin
                        n_key = i_prev_key;
                        n_pay = i_prev_pay;
                    end
                end
            end
            CELL_ROTATE: begin
                if (w_tail) begin
                    n_key = i_wrap_key;
                    n_pay = i_wrap_pay;
                end else begin
                    n_key = i_next_key;
                    n_pay = i_next_pay;
                end
            end
            default: begin
                n_key = r_key;
                n_pay = r_pay;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pay <= n_pay;
    end

    assign o_key = r_key;
    assign o_pay = r_pay;

endmodule

@@ design/sorted_insertion_table.sv @@
// Sorted insertion table.
// The i_item channel takes one item at a time. An insert item (mode 0) places its
// key (day, hours, minutes) and payload in front of the first stored entry whose key
// is not smaller, so equal keys put the newest entry first. Every cell compares its
// entry with the new key at once and either keeps its entry, takes the new one, or
// takes its lower neighbor's, so an insert completes in the cycle it is accepted and
// its single result (accepted or full) is registered on o_result.
// A dump item (mode 1) streams the stored entries in ascending order, one per cycle while
// o_result is not stalled, by rotating the chain toward cell 0 with the oldest head
// wrapping to the tail; after n results the table is back in its original order. The last
// result of every item carries last = 1; a dump of an empty table gives one result of kind empty.
// A dump holds the input off until every stored entry has been rotated out to o_result.
// The result register can be refilled in the cycle it is taken; while o_result is stalled
// the chain holds and no new item is taken.
// Reset clears the entry count and the output valid; cell contents are not reset.
module sorted_insertion_table #(
    parameter int CAPACITY      = sit_pkg::CAPACITY_DEF,
    parameter int PAYLOAD_WIDTH = sit_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sit_in_if.sink     i_item,
    sit_out_if.source  o_result
);
    import sit_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [CNT_W-1:0]         r_idx;
    logic [CNT_W-1:0]         n_idx;

    logic                     r_out_valid;
    t_kind                    r_out_kind;
    t_key                     r_out_key;
    logic [PORT_PAY_W-1:0]    r_out_pay;
    logic                     r_out_last;

    logic                     w_out_free;
    logic                     w_in_fire;
    logic                     w_full;
    logic                     w_dump_last;
    t_cell_ctl                w_ctl;
    logic [PAYLOAD_WIDTH-1:0] w_new_pay;

    logic                     w_lt  [CAPACITY];
    t_key                     w_key [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0] w_pay [CAPACITY];

    assign w_out_free   = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_in_fire    = i_item.valid && i_item.ready;
    assign w_full       = (r_count == FULL_COUNT);
    assign w_dump_last  = ((r_idx + CNT_W'(1)) == r_count);
    assign w_new_pay    = PAYLOAD_WIDTH'(i_item.payload);

    // Broadcast command for the chain.
    always_comb begin
        w_ctl.key = {i_item.day, i_item.hours, i_item.minutes};
        if (w_in_fire && (i_item.mode == MODE_INSERT) && !w_full) begin
            w_ctl.op = CELL_INSERT;
        end else if ((r_state == ST_DUMP) && w_out_free) begin
            w_ctl.op = CELL_ROTATE;
        end else begin
            w_ctl.op = CELL_HOLD;
        end
    end

    // Cell chain: cell 0 holds the smallest key.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                     w_prev_lt;
        t_key                     w_prev_key;
        logic [PAYLOAD_WIDTH-1:0] w_prev_pay;
        t_key                     w_next_key;
        logic [PAYLOAD_WIDTH-1:0] w_next_pay;

        if (g == 0) begin : g_head
            // Nothing sits in front of the head, so it behaves as after a smaller key.
            assign w_prev_lt  = 1'b1;
            assign w_prev_key = w_key[0];
            assign w_prev_pay = w_pay[0];
        end else begin : g_body
            assign w_prev_lt  = w_lt[g-1];
            assign w_prev_key = w_key[g-1];
            assign w_prev_pay = w_pay[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_next_key = w_key[0];
            assign w_next_pay = w_pay[0];
        end else begin : g_mid
            assign w_next_key = w_key[g+1];
            assign w_next_pay = w_pay[g+1];
        end

        sit_cell #(
            .CAPACITY      (CAPACITY),
            .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
            .CELL_IDX      (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_new_pay  (w_new_pay),
            .i_count    (r_count),
            .i_prev_lt  (w_prev_lt),
            .i_prev_key (w_prev_key),
            .i_prev_pay (w_prev_pay),
            .i_next_key (w_next_key),
            .i_next_pay (w_next_pay),
            .i_wrap_key (w_key[0]),
            .i_wrap_pay (w_pay[0]),
            .o_lt       (w_lt[g]),
            .o_key      (w_key[g]),
            .o_pay      (w_pay[g])
        );
    end

    // Sequencer: count, dump index and state.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    if (i_item.mode == MODE_INSERT) begin
                        if (!w_full) begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end else if (r_count != '0) begin
                        n_state = ST_DUMP;
                        n_idx   = '0;
                    end
                end
            end
            ST_DUMP: begin
                if (w_out_free) begin
                    n_idx = r_idx + CNT_W'(1);
                    if (w_dump_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            if (i_item.mode == MODE_INSERT) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= w_full ? KIND_FULL : KIND_ACCEPT;
                r_out_key   <= '0;
                r_out_pay   <= '0;
                r_out_last  <= 1'b1;
            end else if (r_count == '0) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= KIND_EMPTY;
                r_out_key   <= '0;
                r_out_pay   <= '0;
                r_out_last  <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if ((r_state == ST_DUMP) && w_out_free) begin
            r_out_valid <= 1'b1;
            r_out_kind  <= KIND_ENTRY;
            r_out_key   <= w_key[0];
            r_out_pay   <= PORT_PAY_W'(w_pay[0]);
            r_out_last  <= w_dump_last;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.kind        = r_out_kind;
    assign o_result.out_day     = r_out_key[KEY_W-1 -: DAY_W];
    assign o_result.out_hours   = r_out_key[MINUTES_W +: HOURS_W];
    assign o_result.out_minutes = r_out_key[MINUTES_W-1:0];
    assign o_result.out_payload = r_out_pay;
    assign o_result.last        = r_out_last;

endmodule
